FILE: design/jads_pkg.sv
package jads_pkg;

  // Width of one ADC sample.
  localparam int SAMPLE_BITS = 12;

  // Calibration registers are 12 bits wide, the dead band 11 bits.
  localparam int LIM_W = 12;
  localparam int DZ_W = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 3;

  // Signed working width for the comparisons: sums and differences never wrap.
  localparam int WORK_W = ((SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W) + 3;

  // Quotient is at most 100, so seven bits and seven divider steps suffice.
  localparam int QUO_W = 7;
  localparam int DVD_W = LIM_W + QUO_W;
  localparam int POS_W = 8;

  localparam logic signed [POS_W-1:0] POS_MIN = -8'sd100;
  localparam logic signed [POS_W-1:0] POS_MAX = 8'sd100;
  localparam logic [DVD_W-1:0] SCALE = DVD_W'(100);

  localparam logic [LIM_W-1:0] LOW_RESET = LIM_W'(240);
  localparam logic [LIM_W-1:0] HIGH_RESET = LIM_W'(3950);
  localparam logic [LIM_W-1:0] CENTER_RESET = LIM_W'(1955);
  localparam logic [DZ_W-1:0] DEADZONE_RESET = '0;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd4;

  // Decoupling queue between classification and division.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified item: either a fixed result or a division to carry out.
  typedef struct packed {
    logic signed [POS_W-1:0] base;
    logic do_div;
    logic err;
    logic [DVD_W-1:0] dividend;
    logic [LIM_W-1:0] divisor;
  } qent_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic signed [POS_W-1:0] base;
    logic do_div;
    logic err;
    logic [DVD_W-1:0] rem;
    logic [LIM_W-1:0] divisor;
    logic [QUO_W-1:0] quo;
  } dstg_t;

  // Resolve quotient bit k: subtract the shifted divisor when it fits.
  function automatic dstg_t div_step(input dstg_t s, input int k);
    dstg_t r;
    logic [DVD_W:0] shd;
    r = s;
    shd = (DVD_W + 1)'(s.divisor) << k;
    if ({1'b0, s.rem} >= shd) begin
      r.rem = s.rem - shd[DVD_W-1:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: design/jads_front.sv
module jads_front (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [jads_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jads_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [jads_pkg::SAMPLE_BITS-1:0] in_raw_sample,
  output logic push_valid,
  output jads_pkg::qent_t push_data,
  input  logic q_full
);
  import jads_pkg::*;

  logic [LIM_W-1:0] low_r;
  logic [LIM_W-1:0] high_r;
  logic [LIM_W-1:0] center_r;
  logic [DZ_W-1:0] deadzone_r;
  logic invert_r;

  logic signed [WORK_W-1:0] xs, los, his, dn, up, width, num;
  logic seg;
  qent_t ent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= LOW_RESET;
      high_r <= HIGH_RESET;
      center_r <= CENTER_RESET;
      deadzone_r <= DEADZONE_RESET;
      invert_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW: low_r <= cfg_data[LIM_W-1:0];
        REG_HIGH: high_r <= cfg_data[LIM_W-1:0];
        REG_CENTER: center_r <= cfg_data[LIM_W-1:0];
        REG_DEADZONE: deadzone_r <= cfg_data[DZ_W-1:0];
        REG_INVERT: invert_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify the sample and set up the segment division.
  always_comb begin
    xs = $signed({{(WORK_W - SAMPLE_BITS){1'b0}}, in_raw_sample});
    los = $signed({{(WORK_W - LIM_W){1'b0}}, low_r});
    his = $signed({{(WORK_W - LIM_W){1'b0}}, high_r});
    dn = $signed({{(WORK_W - LIM_W){1'b0}}, center_r})
       - $signed({{(WORK_W - DZ_W){1'b0}}, deadzone_r});
    up = $signed({{(WORK_W - LIM_W){1'b0}}, center_r})
       + $signed({{(WORK_W - DZ_W){1'b0}}, deadzone_r});
    seg = 1'b0;
    width = '0;
    num = '0;
    ent.base = '0;
    ent.do_div = 1'b0;
    ent.err = 1'b0;
    ent.dividend = '0;
    ent.divisor = '0;
    if (!invert_r) begin
      if (xs < los) begin
        ent.base = POS_MIN;
      end else if (xs > his) begin
        ent.base = POS_MAX;
      end else if (xs < dn) begin
        seg = 1'b1;
        width = dn - los;
        num = xs - los;
        ent.base = POS_MIN;
      end else if (xs > up) begin
        seg = 1'b1;
        width = his - up;
        num = xs - up;
      end
    end else begin
      if (xs > his) begin
        ent.base = POS_MIN;
      end else if (xs < los) begin
        ent.base = POS_MAX;
      end else if (xs > up) begin
        seg = 1'b1;
        width = his - up;
        num = his - xs;
        ent.base = POS_MIN;
      end else if (xs < dn) begin
        seg = 1'b1;
        width = dn - los;
        num = dn - xs;
      end
    end
    if (seg) begin
      if (width <= 0) begin
        ent.err = 1'b1;
        ent.base = '0;
      end else begin
        // The numerator never exceeds the width, so both fit the limit width.
        ent.do_div = 1'b1;
        ent.divisor = width[LIM_W-1:0];
        ent.dividend = DVD_W'(num[LIM_W-1:0]) * SCALE;
      end
    end
  end

  assign push_valid = in_valid;
  assign push_data = ent;
  assign in_stall = q_full;

endmodule

FILE: design/jads_queue.sv
module jads_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  jads_pkg::qent_t push_data,
  output logic full,
  output logic head_valid,
  output jads_pkg::qent_t head_data,
  input  logic pop
);
  import jads_pkg::*;

  qent_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/jads_back.sv
module jads_back (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  jads_pkg::qent_t head_data,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [jads_pkg::POS_W-1:0] out_position,
  output logic out_span_error
);
  import jads_pkg::*;

  // Stage i holds the partial result after quotient bit QUO_W-1-i.
  dstg_t stg_r [QUO_W];
  dstg_t stg_nxt [QUO_W];
  logic [QUO_W-1:0] vld_r;
  logic [QUO_W:0] rdy;
  dstg_t first;

  logic out_valid_r;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic err_r;

  // Each stage advances when it is empty or its successor advances.
  always_comb begin
    rdy[QUO_W] = !out_valid_r || !out_stall;
    for (int i = QUO_W - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign pop = head_valid && rdy[0];

  always_comb begin
    first.base = head_data.base;
    first.do_div = head_data.do_div;
    first.err = head_data.err;
    first.rem = head_data.dividend;
    first.divisor = head_data.divisor;
    first.quo = '0;
    stg_nxt[0] = div_step(first, QUO_W - 1);
    for (int i = 1; i < QUO_W; i++) begin
      stg_nxt[i] = div_step(stg_r[i-1], QUO_W - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= head_valid;
      end
      for (int i = 1; i < QUO_W; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUO_W; i++) begin
      if (rdy[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  // Final add of the segment offset.
  always_comb begin
    pos_nxt = stg_r[QUO_W-1].base;
    if (stg_r[QUO_W-1].do_div) begin
      pos_nxt = stg_r[QUO_W-1].base + $signed(POS_W'(stg_r[QUO_W-1].quo));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[QUO_W]) begin
      out_valid_r <= vld_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[QUO_W]) begin
      pos_r <= pos_nxt;
      err_r <= stg_r[QUO_W-1].err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_position = pos_r;
  assign out_span_error = err_r;

endmodule

FILE: design/joystick_axis_deadzone_scaler.sv
// Joystick axis dead-zone scaler.
// Each input item is one unsigned ADC sample of one axis; each result item is
// the signed position -100..100 and a flag for a segment of non-positive width.
// Input channel: in_valid, in_stall, in_raw_sample. An item is taken at an edge
// with in_valid high and in_stall low. Result channel: out_valid, out_stall,
// out_position, out_span_error, with the same rule.
// Configuration: cfg_valid, cfg_ready (always high), cfg_index, cfg_data.
// Registers are low limit, high limit, center, dead band and invert, at
// indexes 0 to 4; other indexes are ignored. Write them only while idle.
// From acceptance to out_valid an item passes the queue, the seven stages of
// the restoring divider and one output register. One item is taken every
// cycle while in_stall is low.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled result holds its register; the divider stages and then the
// four-entry queue fill behind it, and in_stall rises when the queue is full.
module joystick_axis_deadzone_scaler (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [jads_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jads_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [jads_pkg::SAMPLE_BITS-1:0] in_raw_sample,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [jads_pkg::POS_W-1:0] out_position,
  output logic out_span_error
);
  import jads_pkg::*;

  // Classified items travel from the front end to the divider through a
  // short queue, so a stall on the output does not stop acceptance at once.
  logic push_valid;
  qent_t push_data;
  logic q_full;
  logic head_valid;
  qent_t head_data;
  logic pop;

  // Front end: configuration registers, range tests, segment set-up.
  jads_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_raw_sample(in_raw_sample),
    .push_valid(push_valid),
    .push_data(push_data),
    .q_full(q_full)
  );

  jads_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(push_valid),
    .push_data(push_data),
    .full(q_full),
    .head_valid(head_valid),
    .head_data(head_data),
    .pop(pop)
  );

  // Back end: pipelined divide of the scaled numerator, then the offset add.
  jads_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_valid(head_valid),
    .head_data(head_data),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_position(out_position),
    .out_span_error(out_span_error)
  );

endmodule
